>>> rtl/sle_pkg.sv
package sle_pkg;

   // default list depth
   localparam int SLE_DEPTH = 16;

   // field widths fixed by the request and response formats
   localparam int KIND_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 4;
   localparam int STATUS_W = 2;
   localparam int FIDX_W   = 4;
   localparam int COUNT_W  = 5;

   typedef logic [KIND_W-1:0]          kind_type;
   typedef logic signed [VALUE_W-1:0]  value_type;
   typedef logic [INDEX_W-1:0]         index_type;
   typedef logic [STATUS_W-1:0]        status_type;
   typedef logic [FIDX_W-1:0]          fidx_type;
   typedef logic [COUNT_W-1:0]         count_type;

   // operation kinds
   localparam kind_type KIND_APPEND = 3'd0;
   localparam kind_type KIND_INSERT = 3'd1;
   localparam kind_type KIND_REMOVE = 3'd2;
   localparam kind_type KIND_SEARCH = 3'd3;
   localparam kind_type KIND_READ   = 3'd4;
   localparam kind_type KIND_CLEAR  = 3'd5;

   // status codes
   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_FULL      = 2'd1;
   localparam status_type ST_NOT_FOUND = 2'd2;
   localparam status_type ST_RANGE     = 2'd3;

endpackage

>>> rtl/sle_if.sv
interface sle_req_if import sle_pkg::*; ();
   logic      valid;
   logic      ready;
   kind_type  kind;
   value_type value;
   index_type index;

   modport source (output valid, output kind, output value, output index, input ready);
   modport sink   (input valid, input kind, input value, input index, output ready);
endinterface

interface sle_rsp_if import sle_pkg::*; ();
   logic       valid;
   logic       ready;
   status_type status;
   fidx_type   found_index;
   value_type  item_value;
   count_type  count;

   modport source (output valid, output status, output found_index, output item_value,
                   output count, input ready);
   modport sink   (input valid, input status, input found_index, input item_value,
                   input count, output ready);
endinterface

>>> rtl/sequential_list_engine.sv
// channel   dir  handshake        payload
// req_chan  in   valid / ready    kind, value, index
// rsp_chan  out  valid / ready    status, found_index, item_value, count
//
// one request at a time; req_chan.ready is high only while the sequencer is idle
// append, clear, unused kinds and full or out-of-range cases: dispatch, then finish
// read: dispatch, read, finish; search: a scan of one entry per cycle over the single
// read port of the entry memory; remove and insert front add a move step per entry
// moved plus a flush and a closing step (only the closing step when nothing moves),
// since each move is one read and one write
// reset (synchronous, active high) empties the list; entry storage is not cleared
// a stalled response holds in the output register; the sequencer waits for it to drain

module sequential_list_engine
   import sle_pkg::*;
#(
   parameter int DEPTH = SLE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   sle_req_if.sink       req_chan,
   sle_rsp_if.source     rsp_chan
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // entry address width
   localparam int CW = $clog2(DEPTH + 1);                 // count width, holds DEPTH
   localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;     // width for index compare

   // sequencer states
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_READ     = 3'd2;
   localparam logic [2:0] S_SCAN     = 3'd3;
   localparam logic [2:0] S_MOVE     = 3'd4;
   localparam logic [2:0] S_FINISH   = 3'd5;

   // entry storage, one read and one write port
   logic [VALUE_W-1:0] mem_ff [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;

   // sequencer and list state
   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   kind_type      kind_ff, kind_in;
   value_type     value_ff, value_in;
   index_type     index_ff, index_in;

   // scan pipeline: ptr is next address to read, cmp tags the data now in rd_data_ff
   logic [CW-1:0] ptr_ff, ptr_in;
   logic          cmp_vld_ff, cmp_vld_in;
   logic [AW-1:0] cmp_addr_ff, cmp_addr_in;

   // move engine: read src, write the data at dst in the next cycle
   logic [AW-1:0] src_ff, src_in;
   logic [AW-1:0] dst_ff, dst_in;
   logic [CW-1:0] moves_ff, moves_in;
   logic          up_ff, up_in;
   logic          pend_ff, pend_in;

   // result held until the output register is free
   status_type    res_status_ff, res_status_in;
   logic [AW-1:0] res_fidx_ff, res_fidx_in;
   value_type     res_ival_ff, res_ival_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   fidx_type      rsp_fidx_ff, rsp_fidx_in;
   value_type     rsp_ival_ff, rsp_ival_in;
   count_type     rsp_count_ff, rsp_count_in;

   logic          accept;
   logic          out_free;
   logic          full;
   logic [XW-1:0] idx_x;
   logic [XW-1:0] cnt_x;
   logic          match;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign full     = (count_ff == CW'(DEPTH));
   assign idx_x    = XW'(index_ff);
   assign cnt_x    = XW'(count_ff);
   assign match    = cmp_vld_ff && (rd_data_ff == value_ff);

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.found_index = rsp_fidx_ff;
   assign rsp_chan.item_value  = rsp_ival_ff;
   assign rsp_chan.count       = rsp_count_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      kind_in       = kind_ff;
      value_in      = value_ff;
      index_in      = index_ff;
      ptr_in        = ptr_ff;
      cmp_vld_in    = 1'b0;
      cmp_addr_in   = cmp_addr_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      moves_in      = moves_ff;
      up_in         = up_ff;
      pend_in       = pend_ff;
      res_status_in = res_status_ff;
      res_fidx_in   = res_fidx_ff;
      res_ival_in   = res_ival_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_fidx_in   = rsp_fidx_ff;
      rsp_ival_in   = rsp_ival_ff;
      rsp_count_in  = rsp_count_ff;
      rd_addr       = ptr_ff[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = src_ff;
      wr_data       = value_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in  = req_chan.kind;
               value_in = req_chan.value;
               index_in = req_chan.index;
               state_in = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            res_status_in = ST_OK;
            res_fidx_in   = '0;
            res_ival_in   = '0;
            state_in      = S_FINISH;
            case (kind_ff)
               KIND_APPEND: begin
                  if (full) begin
                     res_status_in = ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[AW-1:0];
                     wr_data  = value_ff;
                     count_in = count_ff + 1'b1;
                  end
               end
               KIND_INSERT: begin
                  if (full) begin
                     res_status_in = ST_FULL;
                  end else begin
                     // shift entries up, highest first
                     moves_in = count_ff;
                     src_in   = AW'(count_ff - 1'b1);
                     up_in    = 1'b1;
                     pend_in  = 1'b0;
                     state_in = S_MOVE;
                  end
               end
               KIND_REMOVE, KIND_SEARCH: begin
                  ptr_in   = '0;
                  state_in = S_SCAN;
               end
               KIND_READ: begin
                  if (idx_x >= cnt_x) begin
                     res_status_in = ST_RANGE;
                  end else begin
                     rd_addr  = idx_x[AW-1:0];
                     state_in = S_READ;
                  end
               end
               KIND_CLEAR: begin
                  count_in = '0;
               end
               default: begin
               end
            endcase
         end

         S_READ: begin
            res_ival_in = rd_data_ff;
            state_in    = S_FINISH;
         end

         S_SCAN: begin
            if (match) begin
               res_fidx_in = cmp_addr_ff;
               res_ival_in = rd_data_ff;
               if (kind_ff == KIND_REMOVE) begin
                  // close the gap above the match, lowest first
                  moves_in = count_ff - 1'b1 - CW'(cmp_addr_ff);
                  src_in   = cmp_addr_ff + 1'b1;
                  up_in    = 1'b0;
                  pend_in  = 1'b0;
                  state_in = S_MOVE;
               end else begin
                  state_in = S_FINISH;
               end
            end else if (ptr_ff < count_ff) begin
               rd_addr     = ptr_ff[AW-1:0];
               cmp_vld_in  = 1'b1;
               cmp_addr_in = ptr_ff[AW-1:0];
               ptr_in      = ptr_ff + 1'b1;
            end else begin
               res_status_in = ST_NOT_FOUND;
               state_in      = S_FINISH;
            end
         end

         S_MOVE: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = dst_ff;
               wr_data = rd_data_ff;
            end
            if (moves_ff != '0) begin
               rd_addr  = src_ff;
               pend_in  = 1'b1;
               dst_in   = up_ff ? src_ff + 1'b1 : src_ff - 1'b1;
               src_in   = up_ff ? src_ff - 1'b1 : src_ff + 1'b1;
               moves_in = moves_ff - 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  if (up_ff) begin
                     // new value at the front
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     wr_data  = value_ff;
                     count_in = count_ff + 1'b1;
                  end else begin
                     count_in = count_ff - 1'b1;
                  end
                  state_in = S_FINISH;
               end
            end
         end

         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_fidx_in   = FIDX_W'(res_fidx_ff);
               rsp_ival_in   = res_ival_ff;
               rsp_count_in  = COUNT_W'(count_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_vld_ff   <= cmp_vld_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      value_ff      <= value_in;
      index_ff      <= index_in;
      ptr_ff        <= ptr_in;
      cmp_addr_ff   <= cmp_addr_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      moves_ff      <= moves_in;
      up_ff         <= up_in;
      res_status_ff <= res_status_in;
      res_fidx_ff   <= res_fidx_in;
      res_ival_ff   <= res_ival_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fidx_ff   <= rsp_fidx_in;
      rsp_ival_ff   <= rsp_ival_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule
